FILE: hdl/gvn_pkg.sv
// Shared types and constants for the grid vertex normal unit.
// No dependencies; the other files except gvn_line_store refer to it by scoped names.
`default_nettype none

package gvn_pkg;

   // Fixed port widths.
   localparam int FIELD_W   = 16;
   localparam int POS_W     = 10;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET  = 11'd1024;
   localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;

   // Normalization: the largest magnitude is brought into [2^29, 2^30).
   localparam int NORM_W = 30;
   localparam int FRAC_W = 14;
   localparam int Q_W    = 15;
   localparam int LEN_W  = 31;
   localparam int ROOT_W = 63;
   localparam int SQ_W   = 2 * NORM_W;
   localparam int SUMSQ_W = SQ_W + 2;
   localparam int REM_W  = 46;
   localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

   // Result slots of one vertex, in delivery order.
   localparam int SLOT_INTERIOR = 0;
   localparam int SLOT_RIGHT    = 1;
   localparam int SLOT_BOTTOM   = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_NORM,
      ST_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SHIFT,
      NS_SQUARE,
      NS_SUM,
      NS_ROOT,
      NS_LOAD,
      NS_DIVIDE
   } norm_state_type;

   // Status of the Newell accumulator toward the control FSM.
   typedef struct packed {
      logic       done;
      logic       zero;
      logic [2:0] positive;
   } sum_status_type;

endpackage

`default_nettype wire

FILE: hdl/gvn_line_store.sv
// Previous-row line store: one synchronous read-first port with registered read data.
// Depends on nothing else.
`default_nettype none

module gvn_line_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // The old entry is read and the new vertex written in the same beat.
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff   <= mem[addr];
         mem[addr]  <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/gvn_newell_sum.sv
// Newell sum over a four-corner polygon, one edge per cycle on three multipliers.
// Depends on gvn_pkg.
`default_nettype none

module gvn_newell_sum #(
   parameter int CB = 16,
   parameter int SW = 2 * (CB + 1) + 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [3:0][3*CB-1:0]     poly,
   output gvn_pkg::sum_status_type       status,
   output logic      [2:0][SW-1:0]       mag
);

   localparam int D = CB + 1;

   logic [3:0][3*CB-1:0]       v_ff;
   logic [2:0]                 cnt_ff;
   logic                       busy_ff;
   logic                       pv_ff;
   logic                       done_ff;
   logic signed [2*D-1:0]      prod_ff [3];
   logic signed [SW-1:0]       acc_ff  [3];

   logic signed [D-1:0] ax, ay, az, bx, by, bz;
   logic signed [D-1:0] dx, dy, dz, sx, sy, sz;

   assign ax = D'($signed(v_ff[0][CB-1:0]));
   assign ay = D'($signed(v_ff[0][2*CB-1:CB]));
   assign az = D'($signed(v_ff[0][3*CB-1:2*CB]));
   assign bx = D'($signed(v_ff[1][CB-1:0]));
   assign by = D'($signed(v_ff[1][2*CB-1:CB]));
   assign bz = D'($signed(v_ff[1][3*CB-1:2*CB]));
   assign dx = ax - bx;
   assign dy = ay - by;
   assign dz = az - bz;
   assign sx = ax + bx;
   assign sy = ay + by;
   assign sz = az + bz;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            pv_ff   <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            pv_ff  <= (cnt_ff < 3'd4);
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The corners rotate so that the current edge always sits in slots 0 and 1.
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff <= poly;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (busy_ff) begin
         v_ff <= {v_ff[0], v_ff[3], v_ff[2], v_ff[1]};
         prod_ff[0] <= dy * sz;
         prod_ff[1] <= dz * sx;
         prod_ff[2] <= dx * sy;
         if (pv_ff) begin
            for (int i = 0; i < 3; i++) begin
               acc_ff[i] <= acc_ff[i] + SW'(prod_ff[i]);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]             = acc_ff[i][SW-1] ? SW'(-acc_ff[i]) : acc_ff[i];
         status.positive[i] = !acc_ff[i][SW-1] && (acc_ff[i] != '0);
      end
      status.zero = (acc_ff[0] == '0) && (acc_ff[1] == '0) && (acc_ff[2] == '0);
      status.done = done_ff;
   end

endmodule

`default_nettype wire

FILE: hdl/gvn_normalize.sv
// Normalization unit: group shift, squares, bit-serial square root and a
// shared restoring divider. Depends on gvn_pkg.
`default_nettype none

module gvn_normalize #(
   parameter int SW = 36
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [2:0][SW-1:0]                   mag,
   output logic                                      done,
   output logic      [2:0][gvn_pkg::Q_W-1:0]         quot
);

   localparam int MW = (SW > gvn_pkg::NORM_W) ? SW : gvn_pkg::NORM_W + 1;
   localparam int NW = gvn_pkg::NORM_W;

   gvn_pkg::norm_state_type state_ff, state_in;

   logic [MW-1:0]                    mag_ff [3];
   logic [gvn_pkg::SQ_W-1:0]         sq_ff  [3];
   logic [gvn_pkg::SUMSQ_W-1:0]      n_ff;
   logic [gvn_pkg::ROOT_W-1:0]       r_ff;
   logic [gvn_pkg::ROOT_W-1:0]       bit_ff;
   logic [gvn_pkg::REM_W-1:0]        rem_ff;
   logic [gvn_pkg::REM_W-1:0]        d_ff;
   logic [gvn_pkg::Q_W-2:0]          q_ff;
   logic [3:0]                       i_ff;
   logic [1:0]                       j_ff;
   logic                             done_ff;

   logic [MW-1:0]                    m01, m_max;
   logic                             too_big, too_small;
   logic [gvn_pkg::ROOT_W-1:0]       trial;
   logic                             root_ge;
   logic [gvn_pkg::LEN_W-1:0]        len;
   logic                             div_ge;
   logic [gvn_pkg::Q_W-1:0]          q_final;

   assign m01       = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign m_max     = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
   assign too_big   = |m_max[MW-1:NW];
   assign too_small = !m_max[NW-1];
   assign trial     = r_ff + bit_ff;
   assign root_ge   = {1'b0, n_ff} >= trial;
   assign len       = r_ff[gvn_pkg::LEN_W-1:0];
   assign div_ge    = rem_ff >= d_ff;
   assign q_final   = ({q_ff, div_ge} > gvn_pkg::Q_ONE) ? gvn_pkg::Q_ONE : {q_ff, div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gvn_pkg::NS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == gvn_pkg::NS_DIVIDE) && (i_ff == 4'd14) && (j_ff == 2'd2);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gvn_pkg::NS_IDLE:   if (start) state_in = gvn_pkg::NS_SHIFT;
         gvn_pkg::NS_SHIFT:  if (!too_big && !too_small) state_in = gvn_pkg::NS_SQUARE;
         gvn_pkg::NS_SQUARE: state_in = gvn_pkg::NS_SUM;
         gvn_pkg::NS_SUM:    state_in = gvn_pkg::NS_ROOT;
         gvn_pkg::NS_ROOT:   if (bit_ff[0]) state_in = gvn_pkg::NS_LOAD;
         gvn_pkg::NS_LOAD:   state_in = gvn_pkg::NS_DIVIDE;
         gvn_pkg::NS_DIVIDE: begin
            if (i_ff == 4'd14) begin
               state_in = (j_ff == 2'd2) ? gvn_pkg::NS_IDLE : gvn_pkg::NS_LOAD;
            end
         end
         default:            state_in = gvn_pkg::NS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         gvn_pkg::NS_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= MW'(mag[i]);
               end
            end
         end
         gvn_pkg::NS_SHIFT: begin
            // The whole vector moves one bit a cycle until the peak is in range.
            for (int i = 0; i < 3; i++) begin
               if (too_big) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (too_small) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         gvn_pkg::NS_SQUARE: begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= mag_ff[i][NW-1:0] * mag_ff[i][NW-1:0];
            end
         end
         gvn_pkg::NS_SUM: begin
            n_ff   <= gvn_pkg::SUMSQ_W'(sq_ff[0]) + gvn_pkg::SUMSQ_W'(sq_ff[1])
                      + gvn_pkg::SUMSQ_W'(sq_ff[2]);
            r_ff   <= '0;
            bit_ff <= {1'b1, {(gvn_pkg::ROOT_W-1){1'b0}}};
            j_ff   <= '0;
         end
         gvn_pkg::NS_ROOT: begin
            if (root_ge) begin
               n_ff <= gvn_pkg::SUMSQ_W'({1'b0, n_ff} - trial);
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         gvn_pkg::NS_LOAD: begin
            rem_ff <= gvn_pkg::REM_W'({mag_ff[j_ff][NW-1:0], {gvn_pkg::FRAC_W{1'b0}}})
                      + gvn_pkg::REM_W'(len[gvn_pkg::LEN_W-1:1]);
            d_ff   <= gvn_pkg::REM_W'({len, {gvn_pkg::FRAC_W{1'b0}}});
            i_ff   <= '0;
            q_ff   <= '0;
         end
         gvn_pkg::NS_DIVIDE: begin
            if (div_ge) begin
               rem_ff <= rem_ff - d_ff;
            end
            d_ff <= d_ff >> 1;
            q_ff <= {q_ff[gvn_pkg::Q_W-3:0], div_ge};
            i_ff <= i_ff + 4'd1;
            if (i_ff == 4'd14) begin
               quot[j_ff] <= q_final;
               j_ff       <= j_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/grid_vertex_normal_newell_unit.sv
// Top level of the grid vertex normal unit: control FSM, counters, registers.
// Depends on gvn_pkg, gvn_line_store, gvn_newell_sum and gvn_normalize.
//
//   Port group  Direction  Contents
//   req_*       in         one grid vertex (x, y, z) per beat
//   rsp_*       out        one normal with column, row, degenerate, last per beat
//   csr_*       in         register index and write data per beat
//
// One vertex is in flight at a time. A vertex with an interior normal passes
// from its beat through a line store read, the Newell sum, the group shift
// steps, the squares and their sum, the square root, the three divisions and
// a hand-over to its first result, then emits one result per cycle while
// rsp_ready is high. A zero sum skips normalization. Other vertices go from
// the line store read straight to their results, if they have any.
// Reset sets both registers to 1024 and the position to column 0, row 0; the
// line store is not cleared. A stalled result holds the FSM in its emit state.
`default_nettype none

module grid_vertex_normal_newell_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [gvn_pkg::FIELD_W-1:0]     req_vertex_x,
   input  wire logic signed [gvn_pkg::FIELD_W-1:0]     req_vertex_y,
   input  wire logic signed [gvn_pkg::FIELD_W-1:0]     req_vertex_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [gvn_pkg::FIELD_W-1:0]     rsp_normal_x,
   output logic signed      [gvn_pkg::FIELD_W-1:0]     rsp_normal_y,
   output logic signed      [gvn_pkg::FIELD_W-1:0]     rsp_normal_z,
   output logic             [gvn_pkg::POS_W-1:0]       rsp_column,
   output logic             [gvn_pkg::POS_W-1:0]       rsp_row,
   output logic                                        rsp_degenerate,
   output logic                                        rsp_last,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic        [gvn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [gvn_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int CB  = COORD_BITS;
   localparam int VW  = 3 * CB;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int SW  = 2 * (CB + 1) + 2;
   localparam int WW  = 13;
   localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

   gvn_pkg::top_state_type state_ff, state_in;

   logic [CB-1:0]               in_x, in_y, in_z;
   logic [VW-1:0]               in_vertex;
   logic [VW-1:0]               cur_ff, hold_ff, prev_ff;
   logic [VW-1:0]               old_up;
   logic [CW-1:0]               col_ff, c_ff;
   logic [gvn_pkg::POS_W-1:0]   row_ff, r_ff;
   logic [2:0]                  mask_ff;
   logic                        deg_ff;
   logic [gvn_pkg::CFG_W-1:0]   gw_ff, gh_ff;

   logic                        req_fire, csr_fire, rsp_fire;
   logic [WW-1:0]               w_eff;
   logic [gvn_pkg::CFG_W-1:0]   h_eff;
   logic                        end_row, end_frame;
   logic                        only_one;
   logic                        sel_int, sel_right;

   gvn_pkg::sum_status_type     sum_st;
   logic [2:0][SW-1:0]          mag;
   logic                        sum_start, norm_start, norm_done;
   logic [2:0][gvn_pkg::Q_W-1:0] quot;

   // Coordinates are the low COORD_BITS of each field, two's complement; a wider COORD_BITS zero-extends the field.
   if (CB <= gvn_pkg::FIELD_W) begin : g_narrow
      assign in_x = req_vertex_x[CB-1:0];
      assign in_y = req_vertex_y[CB-1:0];
      assign in_z = req_vertex_z[CB-1:0];
   end else begin : g_wide
      assign in_x = CB'($unsigned(req_vertex_x));
      assign in_y = CB'($unsigned(req_vertex_y));
      assign in_z = CB'($unsigned(req_vertex_z));
   end
   assign in_vertex = {in_z, in_y, in_x};

   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   assign w_eff = (gw_ff == '0) ? WW'(1) :
                  ((WW'(gw_ff) > MAXW) ? MAXW : WW'(gw_ff));
   assign h_eff = (gh_ff == '0) ? gvn_pkg::CFG_W'(1) :
                  ((gh_ff > gvn_pkg::MAX_HEIGHT) ? gvn_pkg::MAX_HEIGHT : gh_ff);
   assign end_row   = (WW'(col_ff) + WW'(1)) >= w_eff;
   assign end_frame = (gvn_pkg::CFG_W'(row_ff) + gvn_pkg::CFG_W'(1)) >= h_eff;

   gvn_line_store #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (VW)
   ) u_store (
      .clock (clock),
      .en    (req_fire),
      .addr  (col_ff),
      .wdata (in_vertex),
      .rdata (old_up)
   );

   assign sum_start  = (state_ff == gvn_pkg::ST_READ) && mask_ff[gvn_pkg::SLOT_INTERIOR];
   assign norm_start = (state_ff == gvn_pkg::ST_SUM) && sum_st.done && !sum_st.zero;

   gvn_newell_sum #(
      .CB (CB),
      .SW (SW)
   ) u_sum (
      .clock  (clock),
      .reset  (reset),
      .start  (sum_start),
      .poly   ({prev_ff, cur_ff, old_up, hold_ff}),
      .status (sum_st),
      .mag    (mag)
   );

   gvn_normalize #(
      .SW (SW)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .mag   (mag),
      .done  (norm_done),
      .quot  (quot)
   );

   assign only_one = (mask_ff & (mask_ff - 3'd1)) == 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gvn_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         gw_ff    <= gvn_pkg::CFG_RESET;
         gh_ff    <= gvn_pkg::CFG_RESET;
         mask_ff  <= '0;
         hold_ff  <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            unique case (csr_index)
               gvn_pkg::CSR_GRID_WIDTH:  gw_ff <= csr_wdata;
               gvn_pkg::CSR_GRID_HEIGHT: gh_ff <= csr_wdata;
               default: begin
               end
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_fire) begin
            if (end_row) begin
               col_ff <= '0;
               row_ff <= end_frame ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (req_fire) begin
            mask_ff[gvn_pkg::SLOT_INTERIOR] <= (row_ff != '0) && (col_ff != '0);
            mask_ff[gvn_pkg::SLOT_RIGHT]    <= (row_ff != '0) && end_row;
            mask_ff[gvn_pkg::SLOT_BOTTOM]   <= end_frame;
         end else if (rsp_fire) begin
            mask_ff <= mask_ff & (mask_ff - 3'd1);
         end
         // The upper-left corner and the left neighbour advance once per vertex.
         if (state_ff == gvn_pkg::ST_READ) begin
            hold_ff <= old_up;
            prev_ff <= cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff <= in_vertex;
         c_ff   <= col_ff;
         r_ff   <= row_ff;
      end
      if (state_ff == gvn_pkg::ST_SUM && sum_st.done) begin
         deg_ff <= sum_st.zero;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gvn_pkg::ST_IDLE: if (req_fire) state_in = gvn_pkg::ST_READ;
         gvn_pkg::ST_READ: begin
            priority if (mask_ff == 3'd0) state_in = gvn_pkg::ST_IDLE;
            else if (mask_ff[gvn_pkg::SLOT_INTERIOR]) state_in = gvn_pkg::ST_SUM;
            else state_in = gvn_pkg::ST_EMIT;
         end
         gvn_pkg::ST_SUM: begin
            if (sum_st.done) begin
               state_in = sum_st.zero ? gvn_pkg::ST_EMIT : gvn_pkg::ST_NORM;
            end
         end
         gvn_pkg::ST_NORM: if (norm_done) state_in = gvn_pkg::ST_EMIT;
         gvn_pkg::ST_EMIT: if (rsp_fire && only_one) state_in = gvn_pkg::ST_IDLE;
         default:          state_in = gvn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == gvn_pkg::ST_IDLE) && !reset;
      rsp_valid = (state_ff == gvn_pkg::ST_EMIT);
      csr_ready = !reset;
   end

   // The lowest pending slot is the one on the output.
   assign sel_int   = mask_ff[gvn_pkg::SLOT_INTERIOR];
   assign sel_right = !sel_int && mask_ff[gvn_pkg::SLOT_RIGHT];

   always_comb begin
      if (sel_int && !deg_ff) begin
         rsp_normal_x = sum_st.positive[0] ? -$signed({1'b0, quot[0]}) : $signed({1'b0, quot[0]});
         rsp_normal_y = sum_st.positive[1] ? -$signed({1'b0, quot[1]}) : $signed({1'b0, quot[1]});
         rsp_normal_z = sum_st.positive[2] ? -$signed({1'b0, quot[2]}) : $signed({1'b0, quot[2]});
      end else begin
         rsp_normal_x = '0;
         rsp_normal_y = '0;
         rsp_normal_z = '0;
      end
      rsp_column     = gvn_pkg::POS_W'(sel_int ? c_ff - 1'b1 : c_ff);
      rsp_row        = (sel_int || sel_right) ? r_ff - 1'b1 : r_ff;
      rsp_degenerate = sel_int ? deg_ff : 1'b1;
      rsp_last       = only_one;
   end

endmodule

`default_nettype wire
